/* design/peq_pkg.sv */
// Shared types and constants for the pointer event queue.
`default_nettype none

package peq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int RES_DEPTH = 4;
  localparam int RES_IDX_W = $clog2(RES_DEPTH);

  localparam logic [15:0] WIDTH_RESET = 16'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;
  localparam logic [15:0] DC_WINDOW_RESET = 16'd300;
  localparam logic [19:0] DC_RADIUS_SQ_RESET = 20'd25;

  typedef enum logic [2:0] {
    CMD_MOVE_REL = 3'd0,
    CMD_MOVE_ABS = 3'd1,
    CMD_BTN_DOWN = 3'd2,
    CMD_BTN_UP   = 3'd3,
    CMD_KEY_DOWN = 3'd4,
    CMD_KEY_UP   = 3'd5,
    CMD_POLL     = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    EV_MOVE     = 3'd0,
    EV_BTN_DOWN = 3'd1,
    EV_BTN_UP   = 3'd2,
    EV_KEY_DOWN = 3'd3,
    EV_KEY_UP   = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_DC_WINDOW     = 2'd2,
    REG_DC_RADIUS_SQ  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  modifiers;
    logic [7:0]  key;
    logic        double_click;
    logic [7:0]  buttons;
    logic [15:0] y;
    logic [15:0] x;
    logic [31:0] stamp;
    logic [2:0]  kind;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage

`default_nettype wire

/* design/peq_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module peq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/pointer_event_queue.sv */
// Pointer event queue: pointer tracking, event records and a ring queue of events.
// One command transfer is taken per clock. Move and button commands update the
// pointer and button state at once; they and key commands are written into the
// queue memory in the following cycle, after the squared-distance check of the
// double-click test. A poll reads the queue memory through its registered port
// in stage 2; its result passes the stage-3 registers into a four-entry result
// buffer and waits there. Input ready drops while four poll results are in flight
// or waiting. The queue has no clearing pass after reset.
`default_nettype none

module pointer_event_queue
  import peq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: pos_x[16:0], pos_y[33:17], button_bits[41:34], key_code[49:42],
  //        key_modifiers[57:50], timestamp[89:58], zero fill
  input  wire logic [95:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: event_valid[0], event_time[32:1], event_x[48:33], event_y[64:49],
  //        event_buttons[72:65], double_click[73], event_key[81:74],
  //        event_modifiers[89:82], zero fill
  output logic      [95:0] m_axis_tdata,
  // tuser: event_kind[2:0]
  output logic      [2:0]  m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  // configuration
  logic [15:0] scr_width;
  logic [15:0] scr_height;
  logic [15:0] dc_window;
  logic [19:0] dc_radius_sq;

  // pointer state
  logic [15:0] pointer_x;
  logic [15:0] pointer_y;
  logic [7:0]  button_state;
  logic [31:0] last_press_time;
  logic [15:0] last_press_x;
  logic [15:0] last_press_y;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;

  // input fields
  cmd_t               cmd;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic [7:0]         button_bits;
  logic [7:0]         key_code;
  logic [7:0]         key_modifiers;
  logic [31:0]        timestamp;

  assign cmd           = cmd_t'(s_axis_tuser);
  assign pos_x         = s_axis_tdata[16:0];
  assign pos_y         = s_axis_tdata[33:17];
  assign button_bits   = s_axis_tdata[41:34];
  assign key_code      = s_axis_tdata[49:42];
  assign key_modifiers = s_axis_tdata[57:50];
  assign timestamp     = s_axis_tdata[89:58];

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  function automatic logic [15:0] clamp_coord(input logic signed [17:0] v,
                                              input logic [15:0] dim);
    logic [15:0] r;
    if (v[17]) begin
      r = '0;
    end else if (v[16]) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    if (dim != '0 && r >= dim) begin
      r = dim - 16'd1;
    end
    return r;
  endfunction

  // stage 1: state update and queue decision
  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;
  logic [15:0]        move_x;
  logic [15:0]        move_y;
  logic [15:0]        pointer_x_next;
  logic [15:0]        pointer_y_next;
  logic [7:0]         button_state_next;
  logic               enq;
  logic               is_poll;
  logic               press;
  logic [31:0]        dt;
  logic               dt_ok;
  logic [2:0]         ev_kind;
  logic [IDX_W-1:0]   write_slot_next;
  logic [IDX_W-1:0]   read_slot_next;
  logic               q_full;
  logic               q_empty;
  record_t            rec;

  assign sum_x = (cmd == CMD_MOVE_REL) ?
                 $signed({2'b00, pointer_x}) + $signed({pos_x[16], pos_x}) :
                 $signed({pos_x[16], pos_x});
  assign sum_y = (cmd == CMD_MOVE_REL) ?
                 $signed({2'b00, pointer_y}) + $signed({pos_y[16], pos_y}) :
                 $signed({pos_y[16], pos_y});
  assign move_x = clamp_coord(sum_x, scr_width);
  assign move_y = clamp_coord(sum_y, scr_height);

  assign write_slot_next = (write_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign read_slot_next  = (read_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : read_index + 1'b1;
  assign q_full  = (write_slot_next == read_index);
  assign q_empty = (write_index == read_index);

  assign dt    = timestamp - last_press_time;
  assign dt_ok = (dt <= {16'd0, dc_window});

  always_comb begin
    pointer_x_next    = pointer_x;
    pointer_y_next    = pointer_y;
    button_state_next = button_state;
    enq               = 1'b0;
    is_poll           = 1'b0;
    press             = 1'b0;
    ev_kind           = EV_MOVE;
    unique case (cmd) inside
      CMD_MOVE_REL, CMD_MOVE_ABS: begin
        pointer_x_next    = move_x;
        pointer_y_next    = move_y;
        button_state_next = button_bits;
        enq               = 1'b1;
        ev_kind           = EV_MOVE;
      end
      CMD_BTN_DOWN: begin
        button_state_next = button_state | button_bits;
        press             = button_bits[0] && !button_state[0];
        enq               = 1'b1;
        ev_kind           = EV_BTN_DOWN;
      end
      CMD_BTN_UP: begin
        button_state_next = button_state & ~button_bits;
        enq               = 1'b1;
        ev_kind           = EV_BTN_UP;
      end
      CMD_KEY_DOWN: begin
        enq     = 1'b1;
        ev_kind = EV_KEY_DOWN;
      end
      CMD_KEY_UP: begin
        enq     = 1'b1;
        ev_kind = EV_KEY_UP;
      end
      CMD_POLL: begin
        is_poll = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec              = '0;
    rec.kind         = ev_kind;
    rec.stamp        = timestamp;
    rec.x            = pointer_x_next;
    rec.y            = pointer_y_next;
    rec.buttons      = button_state_next;
    rec.double_click = 1'b0;
    if (cmd == CMD_KEY_DOWN || cmd == CMD_KEY_UP) begin
      rec.key       = key_code;
      rec.modifiers = key_modifiers;
    end
  end

  // stage 2 registers
  logic                s2_wr;
  logic                s2_poll;
  logic                s2_hit;
  logic [IDX_W-1:0]    s2_addr;
  record_t             s2_rec;
  logic                s2_press_ok;
  logic signed [16:0]  s2_dx;
  logic signed [16:0]  s2_dy;

  // stage 3 registers
  logic s3_poll;
  logic s3_hit;

  // result buffer
  logic [REC_W:0]       res_buf [RES_DEPTH];
  logic [RES_IDX_W-1:0] res_wr;
  logic [RES_IDX_W-1:0] res_rd;
  logic [RES_IDX_W:0]   res_count;
  logic [RES_IDX_W:0]   pending;
  logic                 res_push;
  logic                 res_pop;

  assign pending = res_count + (RES_IDX_W + 1)'(s2_poll) + (RES_IDX_W + 1)'(s3_poll);
  assign s_axis_tready = (pending < (RES_IDX_W + 1)'(RES_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_width       <= WIDTH_RESET;
      scr_height      <= HEIGHT_RESET;
      dc_window       <= DC_WINDOW_RESET;
      dc_radius_sq    <= DC_RADIUS_SQ_RESET;
      pointer_x       <= WIDTH_RESET >> 1;
      pointer_y       <= HEIGHT_RESET >> 1;
      button_state    <= '0;
      last_press_time <= '0;
      last_press_x    <= WIDTH_RESET >> 1;
      last_press_y    <= HEIGHT_RESET >> 1;
      write_index     <= '0;
      read_index      <= '0;
      s2_wr           <= 1'b0;
      s2_poll         <= 1'b0;
      s2_hit          <= 1'b0;
      s2_press_ok     <= 1'b0;
    end else begin
      s2_wr       <= in_fire && enq && !q_full;
      s2_poll     <= in_fire && is_poll;
      s2_hit      <= in_fire && is_poll && !q_empty;
      s2_press_ok <= press && dt_ok;
      if (in_fire) begin
        pointer_x    <= pointer_x_next;
        pointer_y    <= pointer_y_next;
        button_state <= button_state_next;
        if (press) begin
          last_press_time <= timestamp;
          last_press_x    <= pointer_x;
          last_press_y    <= pointer_y;
        end
        if (enq && !q_full) begin
          write_index <= write_slot_next;
        end
        if (is_poll && !q_empty) begin
          read_index <= read_slot_next;
        end
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SCREEN_WIDTH: begin
            scr_width <= cfg_data[15:0];
            pointer_x <= cfg_data[15:0] >> 1;
            pointer_y <= scr_height >> 1;
          end
          REG_SCREEN_HEIGHT: begin
            scr_height <= cfg_data[15:0];
            pointer_x  <= scr_width >> 1;
            pointer_y  <= cfg_data[15:0] >> 1;
          end
          REG_DC_WINDOW:    dc_window    <= cfg_data[15:0];
          REG_DC_RADIUS_SQ: dc_radius_sq <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr <= is_poll ? read_index : write_index;
    s2_rec  <= rec;
    s2_dx   <= $signed({1'b0, pointer_x}) - $signed({1'b0, last_press_x});
    s2_dy   <= $signed({1'b0, pointer_y}) - $signed({1'b0, last_press_y});
  end

  // stage 2: distance check and queue memory access
  logic signed [33:0] sq_x;
  logic signed [33:0] sq_y;
  logic [32:0]        d2;
  logic               d2_ok;
  record_t            wr_rec;
  logic [REC_W-1:0]   ram_q;

  assign sq_x  = s2_dx * s2_dx;
  assign sq_y  = s2_dy * s2_dy;
  assign d2    = {1'b0, sq_x[31:0]} + {1'b0, sq_y[31:0]};
  assign d2_ok = (d2 <= {13'd0, dc_radius_sq});

  always_comb begin
    wr_rec              = s2_rec;
    wr_rec.double_click = s2_press_ok && d2_ok;
  end

  peq_ram #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (s2_wr),
    .waddr(s2_addr),
    .wdata(wr_rec),
    .re   (s2_hit),
    .raddr(s2_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_poll <= 1'b0;
      s3_hit  <= 1'b0;
    end else begin
      s3_poll <= s2_poll;
      s3_hit  <= s2_hit;
    end
  end

  // result buffer
  assign res_push = s3_poll;
  assign res_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_buf[res_wr] <= s3_hit ? {1'b1, ram_q} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + 1'b1;
      end
      if (res_pop) begin
        res_rd <= res_rd + 1'b1;
      end
      case ({res_push, res_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  logic [REC_W:0] head;
  record_t        head_rec;

  assign head     = res_buf[res_rd];
  assign head_rec = head[REC_W-1:0];

  assign m_axis_tvalid = (res_count != '0);
  assign m_axis_tuser  = head_rec.kind;
  assign m_axis_tdata  = {6'd0, head_rec.modifiers, head_rec.key, head_rec.double_click,
                          head_rec.buttons, head_rec.y, head_rec.x, head_rec.stamp,
                          head[REC_W]};

endmodule

`default_nettype wire

/* design/peq_checker.sv */
// Port-level checks for the pointer event queue, bound to the top level.
`default_nettype none

module peq_checker
  import peq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[95:1] == '0 && m_axis_tuser == '0)
    else $error("empty poll result not all zero");

  a_dc_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[73] |-> m_axis_tuser == EV_BTN_DOWN)
    else $error("double click on non button-down event");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] && m_axis_tuser != EV_KEY_DOWN &&
    m_axis_tuser != EV_KEY_UP |-> m_axis_tdata[89:74] == '0)
    else $error("key fields set on pointer event");

endmodule

bind pointer_event_queue peq_checker u_peq_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

/* bench/pointer_event_queue_tb.sv */
// Self-checking pointer event queue bench: directed, config, queue-full, stall and random tests.
module pointer_event_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import peq_pkg::*;

  localparam logic [2:0] CMD_RESERVED = 3'd7;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [7:0]         buttons;
    logic [7:0]         key;
    logic [7:0]         mods;
    logic [31:0]        stamp;
  } command_t;

  typedef struct packed {
    logic    present;
    record_t rec;
  } poll_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: pos_x[16:0], pos_y[33:17], button_bits[41:34], key_code[49:42],
  //        key_modifiers[57:50], timestamp[89:58], zero fill
  logic [95:0] s_axis_tdata;
  // tuser: cmd[2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: event_valid[0], event_time[32:1], event_x[48:33], event_y[64:49],
  //        event_buttons[72:65], double_click[73], event_key[81:74],
  //        event_modifiers[89:82], zero fill
  logic [95:0] m_axis_tdata;
  // tuser: event_kind[2:0]
  logic [2:0]  m_axis_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  // tracked block state
  logic [15:0] scr_w, scr_h, dc_window;
  logic [19:0] dc_radius_sq;
  logic [15:0] ptr_x, ptr_y;
  logic [7:0]  btn_now;
  logic [31:0] press_stamp;
  logic [15:0] press_x, press_y;
  int          wr_slot, rd_slot;
  record_t     ring [QUEUE_DEPTH];
  poll_result_t due_events[$];

  int          fail_count = 0;
  logic [31:0] tick_ms = 32'd0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          rx_wait = 0;
  int          hold_cycles = 0;

  pointer_event_queue u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] clamp_to_screen(int v, logic [15:0] dim);
    logic [15:0] r;
    if (v < 0) r = 16'd0;
    else if (v > 65535) r = 16'hFFFF;
    else r = v[15:0];
    if (dim != 16'd0 && r >= dim) r = dim - 16'd1;
    return r;
  endfunction

  function automatic void recentre();
    ptr_x = scr_w >> 1;
    ptr_y = scr_h >> 1;
  endfunction

  function automatic void reset_tracker();
    scr_w = WIDTH_RESET;
    scr_h = HEIGHT_RESET;
    dc_window = DC_WINDOW_RESET;
    dc_radius_sq = DC_RADIUS_SQ_RESET;
    recentre();
    btn_now = 8'd0;
    press_stamp = 32'd0;
    press_x = ptr_x;
    press_y = ptr_y;
    wr_slot = 0;
    rd_slot = 0;
  endfunction

  function automatic void push_event(event_kind_t kind, logic [31:0] stamp, logic dc,
                                     logic [7:0] key, logic [7:0] mods);
    int nxt;
    nxt = (wr_slot + 1) % QUEUE_DEPTH;
    if (nxt == rd_slot) return;  // full: dropped
    ring[wr_slot].kind = kind;
    ring[wr_slot].stamp = stamp;
    ring[wr_slot].x = ptr_x;
    ring[wr_slot].y = ptr_y;
    ring[wr_slot].buttons = btn_now;
    ring[wr_slot].double_click = dc;
    ring[wr_slot].key = key;
    ring[wr_slot].modifiers = mods;
    wr_slot = nxt;
  endfunction

  function automatic void track_command(command_t c);
    int nx, ny;
    logic [7:0] prev;
    logic [31:0] dt;
    longint dx, dy;
    logic dc;
    poll_result_t r;
    case (c.cmd) inside
      CMD_MOVE_REL, CMD_MOVE_ABS: begin
        nx = int'($signed(c.pos_x));
        ny = int'($signed(c.pos_y));
        if (c.cmd == CMD_MOVE_REL) begin
          nx = nx + int'(ptr_x);
          ny = ny + int'(ptr_y);
        end
        ptr_x = clamp_to_screen(nx, scr_w);
        ptr_y = clamp_to_screen(ny, scr_h);
        btn_now = c.buttons;
        push_event(EV_MOVE, c.stamp, 1'b0, 8'd0, 8'd0);
      end
      CMD_BTN_DOWN, CMD_BTN_UP: begin
        prev = btn_now;
        dc = 1'b0;
        if (c.cmd == CMD_BTN_DOWN) btn_now = btn_now | c.buttons;
        else btn_now = btn_now & ~c.buttons;
        if (c.cmd == CMD_BTN_DOWN && c.buttons[0] && !prev[0]) begin
          dt = c.stamp - press_stamp;
          dx = longint'(ptr_x) - longint'(press_x);
          dy = longint'(ptr_y) - longint'(press_y);
          dc = (dt <= dc_window) && (dx * dx + dy * dy <= longint'(dc_radius_sq));
          press_stamp = c.stamp;
          press_x = ptr_x;
          press_y = ptr_y;
        end
        if (c.cmd == CMD_BTN_DOWN) push_event(EV_BTN_DOWN, c.stamp, dc, 8'd0, 8'd0);
        else push_event(EV_BTN_UP, c.stamp, dc, 8'd0, 8'd0);
      end
      CMD_KEY_DOWN: push_event(EV_KEY_DOWN, c.stamp, 1'b0, c.key, c.mods);
      CMD_KEY_UP:   push_event(EV_KEY_UP, c.stamp, 1'b0, c.key, c.mods);
      CMD_POLL: begin
        r = '0;
        if (wr_slot != rd_slot) begin
          r.present = 1'b1;
          r.rec = ring[rd_slot];
          rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
        end
        due_events.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void track_config(cfg_reg_t idx, logic [19:0] value);
    case (idx)
      REG_SCREEN_WIDTH: begin
        scr_w = value[15:0];
        recentre();
      end
      REG_SCREEN_HEIGHT: begin
        scr_h = value[15:0];
        recentre();
      end
      REG_DC_WINDOW:    dc_window = value[15:0];
      REG_DC_RADIUS_SQ: dc_radius_sq = value;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_poll
    poll_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_events.size() == 0) begin
        $error("poll result transfer with no poll outstanding");
        fail_count++;
      end else begin
        want = due_events.pop_front();
        check_field("event_valid", 32'(want.present), 32'(m_axis_tdata[0]));
        check_field("event_kind", 32'(want.rec.kind), 32'(m_axis_tuser));
        check_field("event_time", want.rec.stamp, m_axis_tdata[32:1]);
        check_field("event_x", 32'(want.rec.x), 32'(m_axis_tdata[48:33]));
        check_field("event_y", 32'(want.rec.y), 32'(m_axis_tdata[64:49]));
        check_field("event_buttons", 32'(want.rec.buttons), 32'(m_axis_tdata[72:65]));
        check_field("double_click", 32'(want.rec.double_click), 32'(m_axis_tdata[73]));
        check_field("event_key", 32'(want.rec.key), 32'(m_axis_tdata[81:74]));
        check_field("event_modifiers", 32'(want.rec.modifiers), 32'(m_axis_tdata[89:82]));
      end
      rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
    end
  end

  // result side: long hold-off first, then per-transfer stall
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic command_t make_cmd(logic [2:0] cmd, int x, int y, logic [7:0] b,
                                        logic [7:0] k, logic [7:0] m, logic [31:0] ts);
    command_t c;
    c.cmd = cmd;
    c.pos_x = x[16:0];
    c.pos_y = y[16:0];
    c.buttons = b;
    c.key = k;
    c.mods = m;
    c.stamp = ts;
    return c;
  endfunction

  function automatic command_t random_fields();
    command_t c;
    c.cmd = 3'($urandom);
    c.pos_x = 17'($urandom);
    c.pos_y = 17'($urandom);
    c.buttons = 8'($urandom);
    c.key = 8'($urandom);
    c.mods = 8'($urandom);
    c.stamp = $urandom;
    return c;
  endfunction

  function automatic command_t random_command(int poll_pct);
    command_t c;
    int sel;
    if ($urandom_range(0, 15) == 0) tick_ms = tick_ms + $urandom;
    else tick_ms = tick_ms + $urandom_range(0, 180);
    c = random_fields();
    if ($urandom_range(0, 99) < poll_pct) begin
      c.cmd = CMD_POLL;
      return c;
    end
    sel = $urandom_range(0, 99);
    if (sel < 8) return c;  // noise, reserved code included
    c.stamp = tick_ms;
    if (sel < 38) begin
      c.cmd = CMD_MOVE_REL;
      c.pos_x = 17'(int'($urandom_range(0, 8)) - 4);
      c.pos_y = 17'(int'($urandom_range(0, 8)) - 4);
      if ($urandom_range(0, 4) != 0) c.buttons = btn_now;
    end else if (sel < 48) begin
      c.cmd = CMD_MOVE_ABS;
      if ($urandom_range(0, 1) == 0) begin
        c.pos_x = 17'($urandom_range(0, scr_w));
        c.pos_y = 17'($urandom_range(0, scr_h));
      end
      if ($urandom_range(0, 4) != 0) c.buttons = btn_now;
    end else if (sel < 78) begin
      c.cmd = (sel < 63) ? CMD_BTN_DOWN : CMD_BTN_UP;
      if ($urandom_range(0, 9) < 7) c.buttons = 8'h01;
    end else begin
      c.cmd = (sel < 89) ? CMD_KEY_DOWN : CMD_KEY_UP;
    end
    return c;
  endfunction

  function automatic logic [19:0] pick_setting(logic [19:0] top);
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return top;
      2: return 20'd1;
      3: return 20'($urandom_range(2, 2048));
      default: return 20'($urandom) & top;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_command(command_t c);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.cmd;
    s_axis_tdata <= {6'd0, c.stamp, c.mods, c.key, c.buttons, c.pos_y, c.pos_x};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    track_command(c);
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    wait (due_events.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    track_config(idx, value);
    repeat (2) @(negedge clk);
  endtask

  task automatic poll_until_empty();
    while (wr_slot != rd_slot) send_command(make_cmd(CMD_POLL, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_POLL, -1, -1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_directed_events();
    send_command(make_cmd(CMD_POLL, 0, 0, 0, 0, 0, 0));                // empty queue
    send_command(make_cmd(CMD_MOVE_REL, 0, 0, 8'h00, 0, 0, 32'd10));   // reset position
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h03, 0, 0, 32'd50));   // double click
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd60));   // left already held
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'hFF, 0, 0, 32'd80));
    send_command(make_cmd(CMD_MOVE_REL, 3, 4, 8'h00, 0, 0, 32'd90));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd350));  // window and radius edge
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'd360));
    send_command(make_cmd(CMD_MOVE_REL, 0, 1, 8'h00, 0, 0, 32'd370));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd651));  // one tick late
    send_command(make_cmd(CMD_MOVE_ABS, -65536, -65536, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_command(make_cmd(CMD_MOVE_ABS, 65535, 65535, 8'h00, 0, 0, 32'd0));
    send_command(make_cmd(CMD_MOVE_REL, -65536, 65535, 8'h00, 0, 0, 32'd1));
    send_command(make_cmd(CMD_KEY_DOWN, 0, 0, 0, 8'hFF, 8'hFF, 32'hAAAA_5555));
    send_command(make_cmd(CMD_KEY_UP, -1, -1, 8'hFF, 8'h00, 8'h00, 32'h5555_AAAA));
    send_command(make_cmd(CMD_RESERVED, -1, -1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    poll_until_empty();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_SCREEN_WIDTH, 20'd0);
    write_reg(REG_SCREEN_HEIGHT, 20'd0);
    send_command(make_cmd(CMD_MOVE_ABS, 65535, 65535, 8'h00, 0, 0, 32'd100));
    send_command(make_cmd(CMD_MOVE_REL, 65535, 1, 8'h00, 0, 0, 32'd101));
    write_reg(REG_SCREEN_WIDTH, 20'hFFFF);
    write_reg(REG_SCREEN_HEIGHT, 20'd1);
    send_command(make_cmd(CMD_MOVE_ABS, 65535, 5, 8'h00, 0, 0, 32'd102));
    write_reg(REG_DC_WINDOW, 20'd0);
    write_reg(REG_DC_RADIUS_SQ, 20'd0);
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd500));
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'd500));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd500));  // same tick and spot
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'd501));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd501));
    write_reg(REG_DC_WINDOW, 20'hFFFF);
    write_reg(REG_DC_RADIUS_SQ, 20'hFFFFF);
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'd600));
    send_command(make_cmd(CMD_MOVE_REL, -1000, 0, 8'h00, 0, 0, 32'd601));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'd66036));
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'hFFFF_FFE0));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'hFFFF_FFF0));
    send_command(make_cmd(CMD_BTN_UP, 0, 0, 8'h01, 0, 0, 32'hFFFF_FFF8));
    send_command(make_cmd(CMD_BTN_DOWN, 0, 0, 8'h01, 0, 0, 32'h0000_0010));  // tick wrap
    poll_until_empty();
    write_reg(REG_SCREEN_WIDTH, 20'(WIDTH_RESET));
    write_reg(REG_SCREEN_HEIGHT, 20'(HEIGHT_RESET));
    write_reg(REG_DC_WINDOW, 20'(DC_WINDOW_RESET));
    write_reg(REG_DC_RADIUS_SQ, DC_RADIUS_SQ_RESET);
  endtask

  task automatic test_queue_full();
    command_t c;
    repeat (QUEUE_DEPTH + 12) begin
      c = random_fields();
      c.cmd = 3'($urandom_range(CMD_MOVE_REL, CMD_KEY_UP));
      send_command(c);
    end
    poll_until_empty();
  endtask

  task automatic test_result_stall();
    command_t c;
    repeat (24) begin
      c = random_fields();
      c.cmd = CMD_KEY_DOWN;
      send_command(c);
    end
    drain_results();
    tx_idle = 1'b0;
    hold_cycles = 400;
    repeat (24) send_command(make_cmd(CMD_POLL, 0, 0, 0, 0, 0, 0));
    drain_results();  // sender waits for every result
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int poll_pct;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_SCREEN_WIDTH, pick_setting(20'hFFFF));
      write_reg(REG_SCREEN_HEIGHT, pick_setting(20'hFFFF));
      write_reg(REG_DC_WINDOW, (phase == 0) ? 20'hFFFF : pick_setting(20'hFFFF));
      write_reg(REG_DC_RADIUS_SQ, (phase == 0) ? 20'hFFFFF : pick_setting(20'hFFFFF));
      poll_pct = $urandom_range(15, 60);
      repeat (90) send_command(random_command(poll_pct));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_tracker();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_events();
    test_config_extremes();
    test_queue_full();
    test_result_stall();
    test_random_traffic();

    drain_results();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
